// File: rtl/core/dpk_pkg.sv
// Shared types and constants for the depth 11-bit packer.
// No dependencies; used by the front end, back end and top level by scoped name.
package dpk_pkg;

	// Field widths fixed by the interface
	localparam int SAMPLE_W = 16;
	localparam int SCALE_W  = 24;
	localparam int OFFSET_W = 11;
	localparam int WORD_W   = 16;
	localparam int PEND_W   = WORD_W - 1;
	localparam int CNT_W    = 4;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_OFFSET = 2'd2;

	// Register values after reset
	localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd160400;
	localparam logic [OFFSET_W-1:0] OFFSET_RST = 11'd15;

	// Configuration as seen by the coding front end
	typedef struct packed {
		logic                map_mode;
		logic [SCALE_W-1:0]  depth_scale;
		logic [OFFSET_W-1:0] code_offset;
	} cfg_t;

endpackage

// File: rtl/core/dpk_front.sv
// Front end of the depth packer: accepts samples and turns each into a code.
// Raw codes and zero depth skip the divider; mapped codes use a bit-serial restoring divider.
// Depends on dpk_pkg.
module dpk_front #(
	parameter int CODE_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dpk_pkg::cfg_t                 cfg,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [dpk_pkg::SAMPLE_W-1:0]  depth_sample,
	input  logic                          frame_end,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [CODE_BITS-1:0]          res_code,
	output logic                          res_last
);

	localparam int STEP_W = $clog2(dpk_pkg::SCALE_W + 1);
	localparam logic [CODE_BITS-1:0] CODE_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic                            res_valid_q;
	logic [CODE_BITS-1:0]            res_code_q;
	logic                            res_last_q;
	logic                            last_q;
	logic [dpk_pkg::SAMPLE_W-1:0]    rem_q;
	logic [dpk_pkg::SAMPLE_W-1:0]    dsr_q;
	logic [dpk_pkg::SCALE_W-1:0]     quo_q;
	logic [STEP_W-1:0]               step_q;

	logic                            accept;
	logic                            slot_free;
	logic                            need_div;
	logic [CODE_BITS-1:0]            raw_code;
	logic [dpk_pkg::SAMPLE_W:0]      shifted;
	logic [dpk_pkg::SAMPLE_W+1:0]    trial;
	logic                            fits;
	logic [dpk_pkg::SAMPLE_W-1:0]    rem_next;
	logic [dpk_pkg::SCALE_W-1:0]     q_less;
	logic [CODE_BITS-1:0]            map_code;

	// Result slot frees when empty or being taken
	assign slot_free    = !res_valid_q || res_ready;
	assign sample_ready = (state_q == ST_IDLE) && slot_free;
	assign accept       = sample_valid && sample_ready;
	assign need_div     = cfg.map_mode && (depth_sample != '0);

	// Saturate the raw sample; a zero depth in map mode also lands here as zero
	always_comb begin
		if (!cfg.map_mode) begin
			if (depth_sample > dpk_pkg::SAMPLE_W'(CODE_MAX)) raw_code = CODE_MAX;
			else raw_code = depth_sample[CODE_BITS-1:0];
		end else begin
			raw_code = '0;
		end
	end

	// One restoring division step
	always_comb begin
		shifted  = {rem_q, quo_q[dpk_pkg::SCALE_W-1]};
		trial    = {1'b0, shifted} - {2'b00, dsr_q};
		fits     = !trial[dpk_pkg::SAMPLE_W+1];
		rem_next = fits ? trial[dpk_pkg::SAMPLE_W-1:0] : shifted[dpk_pkg::SAMPLE_W-1:0];
	end

	// Subtract the offset from the quotient, clamp to the code range
	always_comb begin
		q_less = quo_q - dpk_pkg::SCALE_W'(cfg.code_offset);
		if (quo_q <= dpk_pkg::SCALE_W'(cfg.code_offset)) map_code = '0;
		else if (q_less > dpk_pkg::SCALE_W'(CODE_MAX)) map_code = CODE_MAX;
		else map_code = q_less[CODE_BITS-1:0];
	end

	// Sequencer, divider and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_code_q  <= '0;
			res_last_q  <= 1'b0;
			last_q      <= 1'b0;
			rem_q       <= '0;
			dsr_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (need_div) begin
							state_q     <= ST_DIV;
							res_valid_q <= 1'b0;
							last_q      <= frame_end;
							rem_q       <= '0;
							dsr_q       <= depth_sample;
							quo_q       <= cfg.depth_scale;
							step_q      <= STEP_W'(dpk_pkg::SCALE_W);
						end else begin
							res_valid_q <= 1'b1;
							res_code_q  <= raw_code;
							res_last_q  <= frame_end;
						end
					end else if (res_ready) begin
						res_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (res_ready) res_valid_q <= 1'b0;
					rem_q  <= rem_next;
					quo_q  <= {quo_q[dpk_pkg::SCALE_W-2:0], fits};
					step_q <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_code_q  <= map_code;
						res_last_q  <= last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_code  = res_code_q;
	assign res_last  = res_last_q;

	// A mapped sample of nonzero depth always starts the divider
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && need_div) |=> (state_q == ST_DIV))
		else $error("divider did not start on a mapped sample");

	// No new transaction while a division is in flight
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_DONE) |-> !sample_ready)
		else $error("sample accepted while dividing");

endmodule

// File: rtl/core/dpk_fifo.sv
// Small register queue decoupling the coding front end from the packer.
// Depends on no package.
module dpk_fifo #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Store entries; no reset needed on the payload
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == AW'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				if (rd_ptr_q == AW'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: rtl/core/dpk_back.sv
// Back end of the depth packer: packs codes MSB first into 16-bit words.
// Holds the leftover bits, flushes a zero-padded word at frame end.
// Depends on dpk_pkg.
module dpk_back #(
	parameter int CODE_BITS = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        entry_valid,
	output logic                        entry_ready,
	input  logic [CODE_BITS-1:0]        entry_code,
	input  logic                        entry_last,
	output logic                        word_valid,
	input  logic                        word_ready,
	output logic [dpk_pkg::WORD_W-1:0]  packed_word,
	output logic                        word_last
);

	localparam int ACC_W = dpk_pkg::PEND_W + CODE_BITS;
	localparam int FW    = dpk_pkg::CNT_W + 1;

	logic [dpk_pkg::PEND_W-1:0]  pend_bits_q;
	logic [dpk_pkg::CNT_W-1:0]   pend_cnt_q;
	logic                        word_valid_q;
	logic [dpk_pkg::WORD_W-1:0]  packed_word_q;
	logic                        word_last_q;
	logic                        flush_pend_q;
	logic [dpk_pkg::WORD_W-1:0]  flush_word_q;

	logic                        out_free;
	logic                        pop;
	logic                        flush_out;
	logic [ACC_W-1:0]            acc;
	logic [FW-1:0]               cnt_full;
	logic [FW-1:0]               cnt_rem;
	logic                        has_word;
	logic [dpk_pkg::WORD_W-1:0]  full_word;
	logic [dpk_pkg::PEND_W-1:0]  keep_bits;
	logic [dpk_pkg::CNT_W-1:0]   keep_cnt;
	logic                        need_flush;
	logic [dpk_pkg::WORD_W-1:0]  flush_word;

	assign out_free    = !word_valid_q || word_ready;
	assign pop         = entry_valid && !flush_pend_q && out_free;
	assign flush_out   = flush_pend_q && out_free;
	assign entry_ready = !flush_pend_q && out_free;

	// Append the code and split off a full word where there is one
	always_comb begin
		acc       = {pend_bits_q, entry_code};
		cnt_full  = FW'(pend_cnt_q) + FW'(CODE_BITS);
		has_word  = (cnt_full >= FW'(dpk_pkg::WORD_W));
		cnt_rem   = cnt_full - FW'(dpk_pkg::WORD_W);
		full_word = dpk_pkg::WORD_W'(acc >> cnt_rem[dpk_pkg::CNT_W-1:0]);
		if (has_word) begin
			keep_cnt  = cnt_rem[dpk_pkg::CNT_W-1:0];
			keep_bits = acc[dpk_pkg::PEND_W-1:0]
				& ~({dpk_pkg::PEND_W{1'b1}} << cnt_rem[dpk_pkg::CNT_W-1:0]);
		end else begin
			keep_cnt  = cnt_full[dpk_pkg::CNT_W-1:0];
			keep_bits = acc[dpk_pkg::PEND_W-1:0];
		end
		need_flush = entry_last && (keep_cnt != '0);
		// Left-align the leftover bits, zeros on the right
		flush_word = {keep_bits, 1'b0}
			<< (dpk_pkg::CNT_W'(dpk_pkg::WORD_W - 1) - keep_cnt);
	end

	// Pending bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q  <= '0;
			pend_cnt_q   <= '0;
			word_valid_q <= 1'b0;
			flush_pend_q <= 1'b0;
		end else begin
			if (pop) begin
				if (has_word) begin
					word_valid_q <= 1'b1;
					flush_pend_q <= need_flush;
				end else begin
					word_valid_q <= need_flush;
				end
				if (entry_last) begin
					pend_bits_q <= '0;
					pend_cnt_q  <= '0;
				end else begin
					pend_bits_q <= keep_bits;
					pend_cnt_q  <= keep_cnt;
				end
			end else if (flush_out) begin
				word_valid_q <= 1'b1;
				flush_pend_q <= 1'b0;
			end else if (word_ready) begin
				word_valid_q <= 1'b0;
			end
		end
	end

	// Word payload; no reset needed
	always_ff @(posedge clk) begin
		if (pop) begin
			if (has_word) begin
				packed_word_q <= full_word;
				word_last_q   <= entry_last && (keep_cnt == '0);
				flush_word_q  <= flush_word;
			end else begin
				packed_word_q <= flush_word;
				word_last_q   <= 1'b1;
			end
		end else if (flush_out) begin
			packed_word_q <= flush_word_q;
			word_last_q   <= 1'b1;
		end
	end

	assign word_valid  = word_valid_q;
	assign packed_word = packed_word_q;
	assign word_last   = word_last_q;

	// The final word of a frame leaves nothing behind
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid_q && word_last_q) |-> (pend_cnt_q == '0 && !flush_pend_q))
		else $error("bits left over after the final word");

	// A flush word only ever waits behind a word already shown
	a_flush_behind: assert property (@(posedge clk) disable iff (!arst_n)
		flush_pend_q |-> (word_valid_q && !word_last_q))
		else $error("flush word pending with no word ahead of it");

endmodule

// File: rtl/core/depth_11bit_packer_unit.sv
// Depth packer top level: codes 16-bit depth samples and packs the codes into 16-bit words.
// Raw mode and zero depth take a new sample every clock while the result slot is free; a word
// passes the result, queue and output registers. A nonzero map sample uses the one-bit-a-cycle
// 24-bit divider, which blocks new samples; a flush word behind a full word holds the packer.
// A two-entry queue sits between coding and packing; reset (arst_n low, asynchronous) clears
// all pending bits and restores the registers. Depends on dpk_pkg, dpk_front, dpk_fifo, dpk_back.
module depth_11bit_packer_unit #(
	parameter int CODE_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [dpk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpk_pkg::SCALE_W-1:0]   cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [dpk_pkg::SAMPLE_W-1:0]  depth_sample,
	input  logic                          frame_end,
	output logic                          word_valid,
	input  logic                          word_ready,
	output logic [dpk_pkg::WORD_W-1:0]    packed_word,
	output logic                          word_last
);

	localparam int ENTRY_W = CODE_BITS + 1;

	dpk_pkg::cfg_t         cfg_q;
	logic                  res_valid;
	logic                  res_ready;
	logic [CODE_BITS-1:0]  res_code;
	logic                  res_last;
	logic                  entry_valid;
	logic                  entry_ready;
	logic [ENTRY_W-1:0]    entry_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_mode    <= 1'b0;
			cfg_q.depth_scale <= dpk_pkg::SCALE_RST;
			cfg_q.code_offset <= dpk_pkg::OFFSET_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				dpk_pkg::CFG_MAP_MODE:    cfg_q.map_mode    <= cfg_data[0];
				dpk_pkg::CFG_DEPTH_SCALE: cfg_q.depth_scale <= cfg_data;
				dpk_pkg::CFG_CODE_OFFSET:
					cfg_q.code_offset <= cfg_data[dpk_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	dpk_front #(
		.CODE_BITS(CODE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.depth_sample (depth_sample),
		.frame_end    (frame_end),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_code     (res_code),
		.res_last     (res_last)
	);

	dpk_fifo #(
		.WIDTH(ENTRY_W),
		.DEPTH(2)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_ready (res_ready),
		.push_data  ({res_last, res_code}),
		.pop_valid  (entry_valid),
		.pop_ready  (entry_ready),
		.pop_data   (entry_data)
	);

	dpk_back #(
		.CODE_BITS(CODE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.entry_ready (entry_ready),
		.entry_code  (entry_data[CODE_BITS-1:0]),
		.entry_last  (entry_data[CODE_BITS]),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.packed_word (packed_word),
		.word_last   (word_last)
	);

endmodule

// File: sim/tb_depth_11bit_packer_unit.sv
// Self-checking testbench for depth_11bit_packer_unit: raw and map coding, MSB-first packing.
// Drives random and directed depth samples with random idling on both channels.
// Depends on dpk_pkg and the depth_11bit_packer_unit RTL.
module tb_depth_11bit_packer_unit;

	localparam int CODE_BITS     = 11;
	localparam int CODE_MAX      = (1 << CODE_BITS) - 1;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_ITEMS   = 64;

	// One packed output word as it is expected to leave the block
	typedef struct packed {
		logic [dpk_pkg::WORD_W-1:0] word;
		logic                       last;
	} packed_out_t;

	// Coding and packing predictor plus the queue of words still due
	class depth_pack_scoreboard;
		logic                         map_mode;
		logic [dpk_pkg::SCALE_W-1:0]  depth_scale;
		logic [dpk_pkg::OFFSET_W-1:0] code_offset;
		logic [31:0]                  pend_bits;
		int unsigned                  pend_count;
		packed_out_t                  words_due[$];
		int                           mismatches;

		function new();
			map_mode    = 1'b0;
			depth_scale = dpk_pkg::SCALE_RST;
			code_offset = dpk_pkg::OFFSET_RST;
			pend_bits   = '0;
			pend_count  = 0;
			mismatches  = 0;
		endfunction

		task report(string msg);
			$display("%0t: MISMATCH %s", $time, msg);
			mismatches++;
		endtask

		function void set_reg(logic [dpk_pkg::CFG_IDX_W-1:0] idx,
				logic [dpk_pkg::SCALE_W-1:0] data);
			case (idx)
				dpk_pkg::CFG_MAP_MODE:    map_mode    = data[0];
				dpk_pkg::CFG_DEPTH_SCALE: depth_scale = data;
				dpk_pkg::CFG_CODE_OFFSET: code_offset = data[dpk_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		endfunction

		// Raw: saturate the sample. Map: scale / depth less offset, clamped to the code range.
		function logic [CODE_BITS-1:0] depth_code(logic [dpk_pkg::SAMPLE_W-1:0] d);
			logic [dpk_pkg::SCALE_W-1:0] quot;
			if (!map_mode)
				return (d > CODE_MAX) ? CODE_BITS'(CODE_MAX) : d[CODE_BITS-1:0];
			if (d == 0)
				return '0;
			quot = depth_scale / d;
			if (quot <= code_offset)
				return '0;
			quot = quot - code_offset;
			return (quot > CODE_MAX) ? CODE_BITS'(CODE_MAX) : quot[CODE_BITS-1:0];
		endfunction

		// Append one code to the pending bits and queue every word it completes or flushes
		function void note_sample(logic [dpk_pkg::SAMPLE_W-1:0] d, logic fe);
			logic [31:0] acc;
			int unsigned cnt;
			packed_out_t w;
			acc = (pend_bits << CODE_BITS) | depth_code(d);
			cnt = pend_count + CODE_BITS;
			if (cnt >= dpk_pkg::WORD_W) begin
				cnt -= dpk_pkg::WORD_W;
				w.word = dpk_pkg::WORD_W'(acc >> cnt);
				w.last = fe && (cnt == 0);
				words_due.push_back(w);
				acc &= (32'd1 << cnt) - 1;
			end
			// flush the remainder, zero padded on the right
			if (fe && cnt > 0) begin
				w.word = dpk_pkg::WORD_W'(acc << (dpk_pkg::WORD_W - cnt));
				w.last = 1'b1;
				words_due.push_back(w);
				acc = '0;
				cnt = 0;
			end
			pend_bits  = acc;
			pend_count = cnt;
		endfunction

		task check_word(logic [dpk_pkg::WORD_W-1:0] word, logic last);
			packed_out_t w;
			if (words_due.size() == 0) begin
				report($sformatf("unexpected word %h last %b", word, last));
				return;
			end
			w = words_due.pop_front();
			if (word !== w.word)
				report($sformatf("packed_word %h, want %h", word, w.word));
			if (last !== w.last)
				report($sformatf("word_last %b, want %b (word %h)", last, w.last, w.word));
		endtask

		function int outstanding();
			return words_due.size();
		endfunction

		task close();
			if (words_due.size() != 0)
				report($sformatf("%0d words never arrived", words_due.size()));
		endtask
	endclass

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          cfg_wen      = 1'b0;
	logic [dpk_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [dpk_pkg::SCALE_W-1:0]   cfg_data     = '0;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	logic [dpk_pkg::SAMPLE_W-1:0]  depth_sample = '0;
	logic                          frame_end    = 1'b0;
	logic                          word_valid;
	logic                          word_ready   = 1'b0;
	logic [dpk_pkg::WORD_W-1:0]    packed_word;
	logic                          word_last;

	depth_pack_scoreboard sb;

	int ready_mode = 0;
	int ready_left = 0;
	int ready_tick = 0;

	depth_11bit_packer_unit #(
		.CODE_BITS(CODE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.depth_sample(depth_sample),
		.frame_end(frame_end),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.packed_word(packed_word),
		.word_last(word_last)
	);

	always #5 clk = ~clk;

	// Receiver: switch between always ready, mostly ready, mostly stalled and a fixed pattern
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(20, 200);
		end
		ready_left--;
		ready_tick++;
		case (ready_mode)
			0: word_ready <= 1'b1;
			1: word_ready <= ($urandom_range(0, 3) != 0);
			2: word_ready <= ($urandom_range(0, 3) == 0);
			default: word_ready <= ((ready_tick % 7) < 3);
		endcase
	end

	// Check every output transaction against the oldest word due
	always @(posedge clk) begin
		if (arst_n && word_valid && word_ready)
			sb.check_word(packed_word, word_last);
	end

	// Present one sample and hold it until the transaction completes; valid is left high
	task automatic send_sample(input logic [dpk_pkg::SAMPLE_W-1:0] d, input logic fe);
		sample_valid <= 1'b1;
		depth_sample <= d;
		frame_end    <= fe;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		sb.note_sample(d, fe);
		@(negedge clk);
	endtask

	task automatic idle_for(input int n);
		sample_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Hold off the sender until every word due has left the block
	task automatic drain();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	// Wait for the block to go quiet, allowing for a sample still in the divider
	task automatic settle();
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [dpk_pkg::CFG_IDX_W-1:0] idx,
			input logic [dpk_pkg::SCALE_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// Write all three registers; unused upper data bits carry noise
	task automatic set_all(input logic mode, input logic [dpk_pkg::SCALE_W-1:0] scale,
			input logic [dpk_pkg::OFFSET_W-1:0] offset);
		write_reg(dpk_pkg::CFG_MAP_MODE, dpk_pkg::SCALE_W'(($urandom << 1) | mode));
		write_reg(dpk_pkg::CFG_DEPTH_SCALE, scale);
		write_reg(dpk_pkg::CFG_CODE_OFFSET,
			dpk_pkg::SCALE_W'(($urandom << dpk_pkg::OFFSET_W) | offset));
	endtask

	function automatic logic [dpk_pkg::SAMPLE_W-1:0] pick_sample(input logic map);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return dpk_pkg::SAMPLE_W'(16'hFFFF - $urandom_range(0, 3));
			2: return map ? dpk_pkg::SAMPLE_W'($urandom_range(1, 256))
			              : dpk_pkg::SAMPLE_W'($urandom_range(CODE_MAX - 8, CODE_MAX + 8));
			3: return dpk_pkg::SAMPLE_W'($urandom_range(0, 4095));
			4: return map ? dpk_pkg::SAMPLE_W'($urandom_range(1, 32))
			              : dpk_pkg::SAMPLE_W'($urandom_range(0, CODE_MAX));
			default: return dpk_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic int frame_len();
		case ($urandom_range(0, 5))
			0: return $urandom_range(1, 3);
			1: return 16;
			2: return 32;
			default: return $urandom_range(4, 40);
		endcase
	endfunction

	// Random frames sent in bursts; the phase always closes on a frame end
	task automatic random_phase(input int n_items);
		int k;
		int in_frame;
		int burst_left;
		logic fe;
		in_frame   = 0;
		burst_left = $urandom_range(1, 40);
		for (k = 0; k < n_items; k++) begin
			if (in_frame == 0)
				in_frame = frame_len();
			in_frame--;
			fe = (in_frame == 0) || (k == n_items - 1);
			if (k == n_items / 2 || $urandom_range(0, 59) == 0)
				drain();
			else if (burst_left == 0) begin
				idle_for($urandom_range(1, 10));
				burst_left = $urandom_range(1, 40);
			end
			if (burst_left > 0)
				burst_left--;
			send_sample(pick_sample(sb.map_mode), fe);
		end
		sample_valid <= 1'b0;
	endtask

	initial begin
		logic [dpk_pkg::SAMPLE_W-1:0] aligned_run [16];
		int i;
		aligned_run = '{16'd2048, 16'd1, 16'd1024, 16'hFFFF, 16'd0, 16'd2046, 16'h5555,
			16'hAAAA, 16'd2047, 16'd3, 16'h0400, 16'h07FE, 16'h8000, 16'd12, 16'h0155, 16'h02AA};
		sb = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Raw mode at reset: lone code flushed, word then flush, aligned frame with no flush
		send_sample(16'd0, 1'b1);
		send_sample(16'd2047, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		for (i = 0; i < 16; i++)
			send_sample(aligned_run[i], i == 15);
		sample_valid <= 1'b0;
		settle();

		// Map mode on reset scale and offset: zero depth, saturation, clamp below offset
		write_reg(dpk_pkg::CFG_MAP_MODE, dpk_pkg::SCALE_W'(1));
		send_sample(16'd0, 1'b0);
		send_sample(16'd80, 1'b0);
		send_sample(16'd40, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		sample_valid <= 1'b0;
		settle();

		// Zero scale gives a zero quotient
		write_reg(dpk_pkg::CFG_DEPTH_SCALE, '0);
		send_sample(16'd1000, 1'b1);
		sample_valid <= 1'b0;
		settle();

		// Random phases across raw, reset-like, extreme and random settings
		set_all(1'b0, dpk_pkg::SCALE_W'($urandom), dpk_pkg::OFFSET_W'($urandom));
		random_phase(PHASE_ITEMS);
		settle();
		set_all(1'b1, dpk_pkg::SCALE_RST, dpk_pkg::OFFSET_RST);
		random_phase(PHASE_ITEMS);
		settle();
		set_all(1'b1, 24'hFFFFFF, 11'd0);
		random_phase(PHASE_ITEMS);
		settle();
		set_all(1'b1, 24'd1, 11'd2047);
		random_phase(PHASE_ITEMS);
		settle();
		set_all(1'b1, dpk_pkg::SCALE_W'($urandom_range(1, 24'hFFFFFF)),
			dpk_pkg::OFFSET_W'($urandom));
		random_phase(PHASE_ITEMS);
		settle();
		set_all(1'b1, dpk_pkg::SCALE_W'($urandom_range(1, 1 << 20)),
			dpk_pkg::OFFSET_W'($urandom_range(0, 63)));
		random_phase(PHASE_ITEMS);
		settle();
		set_all(1'b0, dpk_pkg::SCALE_W'($urandom), dpk_pkg::OFFSET_W'($urandom));
		random_phase(PHASE_ITEMS);
		settle();

		sb.close();
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/dpk_pkg.sv
rtl/core/dpk_front.sv
rtl/core/dpk_fifo.sv
rtl/core/dpk_back.sv
rtl/core/depth_11bit_packer_unit.sv
sim/tb_depth_11bit_packer_unit.sv
